FILE: hdl/spq_pkg.sv
// Shared types and constants for the stable priority queue.
`default_nettype none

package spq_pkg;

	localparam int HandleW = 16;
	localparam int KindW   = 8;
	localparam int PrioW   = 31;
	localparam int StatusW = 3;
	localparam int CountW  = 7;

	// Command codes
	localparam logic CMD_INSERT = 1'b0;
	localparam logic CMD_REMOVE = 1'b1;

	// Status codes
	localparam logic [StatusW-1:0] ST_OK    = 3'd0;
	localparam logic [StatusW-1:0] ST_EMPTY = 3'd1;
	localparam logic [StatusW-1:0] ST_NULL  = 3'd2;
	localparam logic [StatusW-1:0] ST_DUP   = 3'd3;
	localparam logic [StatusW-1:0] ST_FULL  = 3'd4;

	typedef struct packed {
		logic [HandleW-1:0] handle;
		logic [KindW-1:0]   kind;
		logic [PrioW-1:0]   prio;
	} entry_t;

	typedef struct packed {
		logic               command;
		logic [HandleW-1:0] item_handle;
		logic [KindW-1:0]   kind;
		logic [PrioW-1:0]   priority_req;
	} in_word_t;

	typedef struct packed {
		logic [StatusW-1:0] status;
		logic [CountW-1:0]  entry_count;
		logic [HandleW-1:0] out_handle;
		logic [KindW-1:0]   out_kind;
		logic [PrioW-1:0]   out_priority;
	} out_word_t;

	// Control broadcast to every cell
	typedef struct packed {
		logic cmp;   // compare key against stored entry
		logic push;  // insert: shift toward tail from the insertion point
		logic pop;   // remove: shift toward head
	} cell_ctl_t;

endpackage

`default_nettype wire

FILE: hdl/stable_priority_queue.sv
// Stable priority queue top level: command control, cell chain and result register.
// Operation: the compare flags are registered when a word is accepted; a decide step then
// updates the chain and loads the result register, which offers the result.
// A new word is not accepted while the previous one is still waiting to be decided.
// A waiting result holds the chain update until the result register frees up.
// Reset (arst_n low) empties the queue: valid bits and count clear, payload does not.
`default_nettype none

module stable_priority_queue import spq_pkg::*; #(
	parameter int QUEUE_DEPTH = 64
) (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      in_valid,
	output logic           in_ready,
	input  wire in_word_t  in_word,
	output logic           out_valid,
	input  wire logic      out_ready,
	output out_word_t      out_word
);

	localparam int CntW = $clog2(QUEUE_DEPTH + 1);

	logic            busy_q;
	logic            cmd_s1;
	entry_t          new_s1;
	logic [CntW-1:0] count_q;
	logic            out_valid_q;
	out_word_t       out_q;

	logic      accept;
	logic      decide;
	logic      dup_any;
	logic      do_push;
	logic      do_pop;
	logic [CntW-1:0] count_next;
	logic [StatusW-1:0] status_next;
	cell_ctl_t ctl;
	entry_t    key_entry;

	logic   vld [QUEUE_DEPTH];
	logic   reg_flag [QUEUE_DEPTH];
	logic   [QUEUE_DEPTH-1:0] match_vec;
	entry_t ent [QUEUE_DEPTH];

	assign in_ready = !busy_q;
	assign accept   = in_valid && in_ready;
	assign decide   = busy_q && (!out_valid_q || out_ready);

	assign key_entry.handle = in_word.item_handle;
	assign key_entry.kind   = in_word.kind;
	assign key_entry.prio   = in_word.priority_req;

	// Decide the command outcome from the registered compare flags
	assign dup_any = |match_vec;
	always_comb begin
		do_push     = 1'b0;
		do_pop      = 1'b0;
		count_next  = count_q;
		status_next = ST_OK;
		case (cmd_s1)
			CMD_REMOVE: begin
				if (count_q == '0) begin
					status_next = ST_EMPTY;
				end else begin
					do_pop     = 1'b1;
					count_next = count_q - 1'b1;
				end
			end
			default: begin
				if (new_s1.handle == '0) begin
					status_next = ST_NULL;
				end else if (dup_any) begin
					status_next = ST_DUP;
				end else if (count_q == CntW'(QUEUE_DEPTH)) begin
					status_next = ST_FULL;
				end else begin
					do_push    = 1'b1;
					count_next = count_q + 1'b1;
				end
			end
		endcase
	end

	assign ctl.cmp  = accept;
	assign ctl.push = decide && do_push;
	assign ctl.pop  = decide && do_pop;

	// Control: busy flag, count and result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				busy_q <= 1'b1;
			end else if (decide) begin
				busy_q <= 1'b0;
			end
			if (decide) begin
				count_q     <= count_next;
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Hold the accepted word and build the result word
	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_s1 <= in_word.command;
			new_s1 <= key_entry;
		end
		if (decide) begin
			out_q.status      <= status_next;
			out_q.entry_count <= CountW'(count_next);
			if (do_pop) begin
				out_q.out_handle   <= ent[0].handle;
				out_q.out_kind     <= ent[0].kind;
				out_q.out_priority <= ent[0].prio;
			end else begin
				out_q.out_handle   <= '0;
				out_q.out_kind     <= '0;
				out_q.out_priority <= '0;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign out_word  = out_q;

	// Chain of cells, head at index 0
	for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
		logic   l_valid;
		logic   l_region;
		entry_t l_entry;
		logic   r_valid;
		entry_t r_entry;

		if (i == 0) begin : g_head
			assign l_valid  = 1'b0;
			assign l_region = 1'b0;
			assign l_entry  = '0;
		end else begin : g_mid
			assign l_valid  = vld[i-1];
			assign l_region = reg_flag[i-1];
			assign l_entry  = ent[i-1];
		end
		if (i == QUEUE_DEPTH - 1) begin : g_tail
			assign r_valid = 1'b0;
			assign r_entry = '0;
		end else begin : g_body
			assign r_valid = vld[i+1];
			assign r_entry = ent[i+1];
		end

		spq_cell u_cell (
			.clk         (clk),
			.arst_n      (arst_n),
			.ctl         (ctl),
			.key_entry   (key_entry),
			.new_entry   (new_s1),
			.left_valid  (l_valid),
			.left_region (l_region),
			.left_entry  (l_entry),
			.right_valid (r_valid),
			.right_entry (r_entry),
			.valid       (vld[i]),
			.region      (reg_flag[i]),
			.match       (match_vec[i]),
			.entry       (ent[i])
		);
	end

	// Count never passes the depth
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CntW'(QUEUE_DEPTH))
		else $error("entry count above queue depth");

	// Head slot is occupied exactly when the count is nonzero
	a_head_valid: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q != '0) == vld[0])
		else $error("head valid disagrees with count");

	// Tail slot is occupied only when the queue is full
	a_tail_full: assert property (@(posedge clk) disable iff (!arst_n)
		vld[QUEUE_DEPTH-1] |-> (count_q == CntW'(QUEUE_DEPTH)))
		else $error("tail occupied below full count");

	// A decision always produces a result and frees the input side
	a_decide_result: assert property (@(posedge clk) disable iff (!arst_n)
		decide |=> (out_valid_q && !busy_q))
		else $error("decision did not produce a result");

endmodule

`default_nettype wire

FILE: hdl/spq_cell.sv
// One queue slot: holds an entry, compares it against the key, shifts to neighbors.
`default_nettype none

module spq_cell import spq_pkg::*; (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire cell_ctl_t ctl,
	input  wire entry_t    key_entry,
	input  wire entry_t    new_entry,
	input  wire logic      left_valid,
	input  wire logic      left_region,
	input  wire entry_t    left_entry,
	input  wire logic      right_valid,
	input  wire entry_t    right_entry,
	output logic           valid,
	output logic           region,
	output logic           match,
	output entry_t         entry
);

	logic   valid_q;
	logic   gt_q;
	logic   match_q;
	entry_t entry_q;
	logic   take_left;

	// This slot moves on an insert when it is empty or holds a larger priority
	assign region    = !valid_q || gt_q;
	assign take_left = left_region;

	// Control flags: valid bit and compare results
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			gt_q    <= 1'b0;
			match_q <= 1'b0;
		end else begin
			if (ctl.cmp) begin
				gt_q    <= valid_q && (entry_q.prio > key_entry.prio);
				match_q <= valid_q && (entry_q.handle == key_entry.handle);
			end
			if (ctl.pop) begin
				valid_q <= right_valid;
			end else if (ctl.push && region) begin
				valid_q <= take_left ? left_valid : 1'b1;
			end
		end
	end

	// Payload: take right neighbor on pop, left neighbor or new entry on push
	always_ff @(posedge clk) begin
		if (ctl.pop) begin
			entry_q <= right_entry;
		end else if (ctl.push && region) begin
			entry_q <= take_left ? left_entry : new_entry;
		end
	end

	assign valid = valid_q;
	assign match = match_q;
	assign entry = entry_q;

endmodule

`default_nettype wire

FILE: tb/sv/stable_priority_queue_tb.sv
// Self-checking testbench for the stable priority queue: directed, fill/drain and random tests.
`default_nettype none

module stable_priority_queue_tb import spq_pkg::*;;

	localparam int QDepth    = 64;
	localparam int TimeLimit = 2_000_000;

	logic      clk;
	logic      arst_n;
	logic      in_valid;
	logic      in_ready;
	in_word_t  in_word;
	logic      out_valid;
	logic      out_ready = 1'b0;
	out_word_t out_word;

	// Shadow of the queue contents, head first
	entry_t    queued_entries[$];
	// Result words still owed by the block, oldest first
	out_word_t expected_results[$];

	int fail_count   = 0;
	int send_gap_pct = 0;
	int recv_gap_pct = 0;

	stable_priority_queue #(
		.QUEUE_DEPTH(QDepth)
	) i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_word   (in_word),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_word  (out_word)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic bit is_queued(logic [HandleW-1:0] h);
		foreach (queued_entries[i]) begin
			if (queued_entries[i].handle == h)
				return 1'b1;
		end
		return 1'b0;
	endfunction

	function automatic logic [HandleW-1:0] fresh_handle();
		logic [HandleW-1:0] h;
		do
			h = HandleW'($urandom_range(1, 65535));
		while (is_queued(h));
		return h;
	endfunction

	// Apply one command to the shadow queue and return the result word it yields
	function automatic out_word_t apply_command(in_word_t w);
		out_word_t r;
		entry_t    e;
		int        pos;
		r = '0;
		if (w.command == CMD_REMOVE) begin
			if (queued_entries.size() == 0) begin
				r.status = ST_EMPTY;
			end else begin
				e              = queued_entries.pop_front();
				r.status       = ST_OK;
				r.out_handle   = e.handle;
				r.out_kind     = e.kind;
				r.out_priority = e.prio;
			end
		end else if (w.item_handle == '0) begin
			r.status = ST_NULL;
		end else if (is_queued(w.item_handle)) begin
			r.status = ST_DUP;
		end else if (queued_entries.size() >= QDepth) begin
			r.status = ST_FULL;
		end else begin
			// place after every entry of equal or lower priority
			pos = queued_entries.size();
			for (int i = 0; i < queued_entries.size(); i++) begin
				if (queued_entries[i].prio > w.priority_req) begin
					pos = i;
					break;
				end
			end
			e.handle = w.item_handle;
			e.kind   = w.kind;
			e.prio   = w.priority_req;
			queued_entries.insert(pos, e);
			r.status = ST_OK;
		end
		r.entry_count = CountW'(queued_entries.size());
		return r;
	endfunction

	function automatic in_word_t make_word(logic cmd, logic [HandleW-1:0] h,
			logic [KindW-1:0] k, logic [PrioW-1:0] p);
		in_word_t w;
		w.command      = cmd;
		w.item_handle  = h;
		w.kind         = k;
		w.priority_req = p;
		return w;
	endfunction

	// Offer one word, hold it until accepted, then record its expected result.
	// Called and returns right after a rising edge.
	task automatic send_word(in_word_t w);
		while ($urandom_range(99) < send_gap_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_word  <= w;
		do
			@(posedge clk);
		while (!in_ready);
		expected_results.push_back(apply_command(w));
	endtask

	task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
		if (want !== got) begin
			$error("%s: expected %0h, actual %0h", name, want, got);
			fail_count++;
		end
	endtask

	// Stall the receiver at random and check every accepted result word
	always @(posedge clk) begin : result_check
		out_word_t want;
		out_ready <= ($urandom_range(99) >= recv_gap_pct);
		if (arst_n && out_valid && out_ready) begin
			if (expected_results.size() == 0) begin
				$error("result word arrived with none expected");
				fail_count++;
			end else begin
				want = expected_results.pop_front();
				check_field("status", 32'(want.status), 32'(out_word.status));
				check_field("entry_count", 32'(want.entry_count), 32'(out_word.entry_count));
				check_field("out_handle", 32'(want.out_handle), 32'(out_word.out_handle));
				check_field("out_kind", 32'(want.out_kind), 32'(out_word.out_kind));
				check_field("out_priority", 32'(want.out_priority),
					32'(out_word.out_priority));
			end
		end
	end

	// Empty remove, null and duplicate rejects, field extremes, ties kept in arrival order
	task automatic test_directed();
		send_word(make_word(CMD_REMOVE, '1, '1, '1));
		send_word(make_word(CMD_INSERT, 16'h0000, 8'hFF, 31'h7FFF_FFFF));
		send_word(make_word(CMD_INSERT, 16'hFFFF, 8'hFF, 31'h7FFF_FFFF));
		send_word(make_word(CMD_INSERT, 16'h0001, 8'h00, 31'h0));
		send_word(make_word(CMD_INSERT, 16'h0002, 8'h5A, 31'd10));
		send_word(make_word(CMD_INSERT, 16'h0003, 8'hA5, 31'd10));
		send_word(make_word(CMD_INSERT, 16'h0004, 8'h3C, 31'd10));
		send_word(make_word(CMD_INSERT, 16'hFFFF, 8'h11, 31'h0));
		send_word(make_word(CMD_INSERT, 16'h0003, 8'h22, 31'd10));
		send_word(make_word(CMD_INSERT, 16'h8000, 8'h81, 31'd5));
		send_word(make_word(CMD_INSERT, 16'h0000, 8'h00, 31'h0));
		// drain, then one remove past empty
		repeat (7)
			send_word(make_word(CMD_REMOVE, HandleW'($urandom()), KindW'($urandom()),
				PrioW'($urandom())));
	endtask

	// Fill to capacity, hit the full, duplicate and null rejects there, then drain
	task automatic test_fill_and_drain();
		while (queued_entries.size() < QDepth)
			send_word(make_word(CMD_INSERT, fresh_handle(), KindW'($urandom()),
				PrioW'($urandom_range(0, 15))));
		send_word(make_word(CMD_INSERT, fresh_handle(), 8'h00, 31'h0));
		send_word(make_word(CMD_INSERT,
			queued_entries[$urandom_range(0, QDepth - 1)].handle, 8'hFF, 31'h7FFF_FFFF));
		send_word(make_word(CMD_INSERT, 16'h0000, 8'h00, 31'h0));
		while (queued_entries.size() > 0)
			send_word(make_word(CMD_REMOVE, '0, '0, '0));
		send_word(make_word(CMD_REMOVE, '0, '0, '0));
	endtask

	// Random mix with a drifting insert bias so the fill level wanders
	task automatic test_random(int n_words);
		int                 insert_pct;
		int                 r;
		logic [HandleW-1:0] h;
		logic [PrioW-1:0]   p;
		insert_pct = 60;
		for (int i = 0; i < n_words; i++) begin
			if (i % 64 == 0)
				insert_pct = $urandom_range(25, 80);
			if ($urandom_range(99) < insert_pct) begin
				// small handle pool makes duplicates common
				r = $urandom_range(99);
				if (r < 3)
					h = '0;
				else if (r < 60)
					h = HandleW'($urandom_range(1, 96));
				else
					h = HandleW'($urandom_range(1, 65535));
				// small priority range makes ties common
				r = $urandom_range(99);
				if (r < 50)
					p = PrioW'($urandom_range(0, 7));
				else if (r < 60)
					p = r[0] ? '1 : '0;
				else
					p = PrioW'($urandom());
				send_word(make_word(CMD_INSERT, h, KindW'($urandom()), p));
			end else begin
				send_word(make_word(CMD_REMOVE, HandleW'($urandom()), KindW'($urandom()),
					PrioW'($urandom())));
			end
		end
	endtask

	initial begin
		arst_n    = 1'b0;
		in_valid  = 1'b0;
		in_word   = '0;

		send_gap_pct = 20;
		recv_gap_pct = 64;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_random(280);

		send_gap_pct = 64;
		recv_gap_pct = 20;
		test_fill_and_drain();
		test_random(240);

		send_gap_pct = 0;
		recv_gap_pct = 0;
		test_random(270);

		// release the input and let the last results come out
		in_valid <= 1'b0;
		while (expected_results.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);

		if (fail_count == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

	// End a hung run
	initial begin
		#(TimeLimit);
		$display("Verification failed");
		$finish;
	end

endmodule

`default_nettype wire
